FILE: sv/rdlm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdlm_pkg
// shared types and constants of the rms decibel level meter
// ----------------------------------------------------------------------------
package rdlm_pkg;

  localparam int unsigned LVL_W     = 16;
  localparam int unsigned SMP_W     = 16;
  localparam int unsigned SQ_W      = 31;   // one square fits 2^30
  localparam int unsigned EXP_W     = 5;
  localparam int unsigned TAB_W     = 17;
  localparam int unsigned DLT_W     = 13;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned PF_W      = DLT_W + FRAC_W;
  localparam int unsigned DB_W      = 21;   // log2 distance to full scale, q16
  localparam int unsigned PT_W      = 34;
  localparam int unsigned NRM_W     = 17;
  localparam int unsigned PN_W      = 35;

  localparam logic [LVL_W-1:0] THR_RESET  = 16'd328;
  localparam logic [11:0]      DB_NORM_K  = 12'd3288;
  localparam logic [3:0]       QUIET_MEAN = 4'd10;
  localparam logic [EXP_W-1:0] EXP_TOP    = 5'd30;
  localparam logic [DB_W-1:0]  LOG_FULL   = 21'(30 * 65536);
  localparam logic [15:0]      ROUND_HALF = 16'h8000;
  localparam logic [LVL_W-1:0] LVL_FULL   = 16'hFFFF;

  // round(65536 * log2(1 + i/16))
  localparam logic [TAB_W-1:0] LOG_TAB [17] = '{
    17'd0,     17'd5732,  17'd11136, 17'd16248, 17'd21098, 17'd25711,
    17'd30109, 17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472,
    17'd52911, 17'd56228, 17'd59434, 17'd62534, 17'd65536
  };

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_DIV   = 9'b000000010,
    ST_CHECK = 9'b000000100,
    ST_NORM  = 9'b000001000,
    ST_MULF  = 9'b000010000,
    ST_MULT  = 9'b000100000,
    ST_MULN  = 9'b001000000,
    ST_LEVEL = 9'b010000000,
    ST_EMIT  = 9'b100000000
  } state_t;

  typedef struct packed {
    logic acc;        // accumulate accepted sample
    logic clr;        // clear request accepted
    logic div_step;
    logic check;
    logic norm_step;
    logic mul_f;
    logic mul_t;
    logic mul_n;
    logic level;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic blk_end;    // the sample on the input closes its block
    logic div_done;
    logic quiet_loud;
    logic norm_done;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/rdlm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdlm_ctrl
// sequencer: accumulate or clear, divide, check, normalize, three multiply steps, level, emit
// ----------------------------------------------------------------------------
module rdlm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic           in_req,
  output logic           in_tready,
  input  rdlm_pkg::sts_t sts,
  output rdlm_pkg::cmd_t cmd
);

  rdlm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rdlm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == rdlm_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      rdlm_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (in_req) begin
            cmd.clr   = 1'b1;
            state_nxt = rdlm_pkg::ST_EMIT;
          end else begin
            cmd.acc = 1'b1;
            if (sts.blk_end) begin
              state_nxt = rdlm_pkg::ST_DIV;
            end
          end
        end
      end
      rdlm_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = rdlm_pkg::ST_CHECK;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      rdlm_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.quiet_loud ? rdlm_pkg::ST_EMIT : rdlm_pkg::ST_NORM;
      end
      rdlm_pkg::ST_NORM: begin
        if (sts.norm_done) begin
          state_nxt = rdlm_pkg::ST_MULF;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      rdlm_pkg::ST_MULF: begin
        cmd.mul_f = 1'b1;
        state_nxt = rdlm_pkg::ST_MULT;
      end
      rdlm_pkg::ST_MULT: begin
        cmd.mul_t = 1'b1;
        state_nxt = rdlm_pkg::ST_MULN;
      end
      rdlm_pkg::ST_MULN: begin
        cmd.mul_n = 1'b1;
        state_nxt = rdlm_pkg::ST_LEVEL;
      end
      rdlm_pkg::ST_LEVEL: begin
        cmd.level = 1'b1;
        state_nxt = rdlm_pkg::ST_EMIT;
      end
      rdlm_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = rdlm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rdlm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/rdlm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdlm_dp
// square accumulator, restoring divider, log/curve arithmetic, output register
// ----------------------------------------------------------------------------
module rdlm_dp #(
  parameter int unsigned MAX_BLOCK = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rdlm_pkg::cmd_t                cmd,
  output rdlm_pkg::sts_t                sts,
  input  logic signed [rdlm_pkg::SMP_W-1:0] in_sample,
  input  logic                          in_last,
  input  logic                          cfg_valid,
  input  logic [rdlm_pkg::LVL_W-1:0]    cfg_data,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rdlm_pkg::LVL_W-1:0]    out_level
);

  localparam int unsigned CNT_W  = $clog2(MAX_BLOCK + 1);
  localparam int unsigned SUM_W  = 30 + CNT_W;
  localparam int unsigned DCNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  den_r;
  logic [CNT_W-1:0]  rem_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [rdlm_pkg::SQ_W-1:0]  norm_r;
  logic [rdlm_pkg::EXP_W-1:0] exp_r;
  logic [15:0]                base_r;
  logic [rdlm_pkg::PF_W-1:0]  prod_f_r;
  logic [rdlm_pkg::PT_W-1:0]  prod_t_r;
  logic [rdlm_pkg::PN_W-1:0]  prod_n_r;
  logic [rdlm_pkg::LVL_W-1:0] lvl_r;
  logic                       clr_r;
  logic [rdlm_pkg::LVL_W-1:0] held_r;
  logic [rdlm_pkg::LVL_W-1:0] thr_r;
  logic                       out_valid_r;
  logic [rdlm_pkg::LVL_W-1:0] out_level_r;

  logic signed [31:0] sq_s;
  logic [SUM_W-1:0]   sum_add;
  logic [CNT_W-1:0]   cnt_inc;
  logic               blk_end;
  logic [CNT_W:0]     rem_sh;
  logic               ge;
  logic [CNT_W:0]     rem_sub;
  logic               quiet;
  logic               loud;
  logic [3:0]         idx;
  logic [rdlm_pkg::TAB_W-1:0] tab_lo;
  logic [rdlm_pkg::TAB_W-1:0] tab_hi;
  logic [rdlm_pkg::DLT_W-1:0] dlt;
  logic [rdlm_pkg::TAB_W-1:0] frac;
  logic [rdlm_pkg::DB_W-1:0]  lg;
  logic [rdlm_pkg::DB_W-1:0]  log_dist;
  logic [17:0]                t_val;
  logic [rdlm_pkg::NRM_W-1:0] n_val;
  logic [18:0]                lv;
  logic [rdlm_pkg::LVL_W-1:0] diff;
  logic                       fire;

  // accumulate
  assign sq_s    = in_sample * in_sample;
  assign sum_add = sum_r + SUM_W'(sq_s[rdlm_pkg::SQ_W-1:0]);
  assign cnt_inc = cnt_r + CNT_W'(1);
  assign blk_end = in_last || (cnt_inc == CNT_W'(MAX_BLOCK));

  // one quotient bit per step
  assign rem_sh  = {rem_r, quo_r[SUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, den_r});
  assign rem_sub = rem_sh - {1'b0, den_r};

  assign quiet = (quo_r <= SUM_W'(rdlm_pkg::QUIET_MEAN));
  assign loud  = |quo_r[SUM_W-1:30];

  // log2 mantissa from table with linear interpolation
  assign idx    = norm_r[29:26];
  assign tab_lo = rdlm_pkg::LOG_TAB[idx];
  assign tab_hi = rdlm_pkg::LOG_TAB[5'(idx) + 5'd1];
  assign dlt    = rdlm_pkg::DLT_W'(tab_hi - tab_lo);

  assign frac     = {1'b0, base_r} + rdlm_pkg::TAB_W'(prod_f_r[rdlm_pkg::PF_W-1:16]);
  assign lg       = {exp_r, 16'd0} + rdlm_pkg::DB_W'(frac);
  assign log_dist = rdlm_pkg::LOG_FULL - lg;

  assign t_val = prod_t_r[rdlm_pkg::PT_W-1:16];
  assign n_val = t_val[17:16] != 2'd0 ? '0 : rdlm_pkg::NRM_W'(18'h10000 - t_val);

  assign lv = prod_n_r[rdlm_pkg::PN_W-1:16];

  assign diff = (lvl_r > held_r) ? lvl_r - held_r : held_r - lvl_r;
  assign fire = clr_r ? (held_r != '0) : (diff > thr_r);

  always_comb begin
    sts.blk_end    = blk_end;
    sts.div_done   = (dcnt_r == DCNT_W'(SUM_W));
    sts.quiet_loud = quiet || loud;
    sts.norm_done  = norm_r[30];
    sts.out_free   = !out_valid_r || out_tready;
  end

  // control-side registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      cnt_r       <= '0;
      held_r      <= '0;
      thr_r       <= rdlm_pkg::THR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        thr_r <= cfg_data;
      end
      if (cmd.clr || (cmd.acc && blk_end)) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else if (cmd.acc) begin
        sum_r <= sum_add;
        cnt_r <= cnt_inc;
      end
      if (cmd.emit && fire) begin
        held_r      <= lvl_r;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.acc && blk_end) begin
      quo_r  <= sum_add;
      den_r  <= cnt_inc;
      rem_r  <= '0;
      dcnt_r <= '0;
      clr_r  <= 1'b0;
    end else if (cmd.div_step) begin
      quo_r  <= {quo_r[SUM_W-2:0], ge};
      rem_r  <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
    if (cmd.clr) begin
      clr_r <= 1'b1;
      lvl_r <= '0;
    end
    if (cmd.check) begin
      norm_r <= quo_r[rdlm_pkg::SQ_W-1:0];
      exp_r  <= rdlm_pkg::EXP_TOP;
      if (loud) begin
        lvl_r <= rdlm_pkg::LVL_FULL;
      end else begin
        lvl_r <= '0;
      end
    end
    if (cmd.norm_step) begin
      norm_r <= {norm_r[rdlm_pkg::SQ_W-2:0], 1'b0};
      exp_r  <= exp_r - rdlm_pkg::EXP_W'(1);
    end
    if (cmd.mul_f) begin
      base_r   <= tab_lo[15:0];
      prod_f_r <= dlt * norm_r[25:10];
    end
    if (cmd.mul_t) begin
      prod_t_r <= rdlm_pkg::PT_W'(log_dist) * rdlm_pkg::PT_W'(rdlm_pkg::DB_NORM_K)
                + rdlm_pkg::PT_W'(rdlm_pkg::ROUND_HALF);
    end
    if (cmd.mul_n) begin
      prod_n_r <= rdlm_pkg::PN_W'(n_val) * rdlm_pkg::PN_W'(n_val)
                + rdlm_pkg::PN_W'(rdlm_pkg::ROUND_HALF);
    end
    if (cmd.level) begin
      lvl_r <= (lv[18:16] != 3'd0) ? rdlm_pkg::LVL_FULL : lv[15:0];
    end
    if (cmd.emit && fire) begin
      out_level_r <= lvl_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_level  = out_level_r;

endmodule

FILE: sv/rms_db_level_meter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_db_level_meter_unit
// rms audio level meter with a squared decibel display curve
// ----------------------------------------------------------------------------
// Samples are summed as squares, one beat per cycle while in_tready is high,
// until a beat with tlast (or the MAX_BLOCK-th sample) closes the block. The
// block end then runs the mean square through a restoring divider (one
// quotient bit per cycle, 30 + clog2(MAX_BLOCK+1) bits, 43 by default), a
// quiet/full-scale check, a one-bit-per-cycle normalizing shift, three
// registered multiply steps, a level step and an emit step, with in_tready
// low throughout; a quiet or full-scale mean goes from the check straight to
// the emit step. The emit step stretches while an earlier level still waits
// unaccepted. Ordinary sample beats are taken back to back; a clear beat
// also passes through the emit step, which decides its emission. The level
// comes out as unsigned q0.16 only when it moved by more than
// change_threshold from the last emitted level, or, on a clear, as zero when
// the held level was nonzero. A finished level waits in the output register
// while new sample beats are taken.
module rms_db_level_meter_unit #(
  parameter int unsigned MAX_BLOCK = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // sample channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample (signed)
  input  logic [0:0]  in_tuser,   // [0] req_type: 0 sample, 1 clear
  input  logic        in_tlast,   // last_in_block
  // level channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] level, q0.16
  // change threshold register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // change_threshold, q0.16
);

  rdlm_pkg::cmd_t cmd;
  rdlm_pkg::sts_t sts;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  rdlm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_req    (in_tuser[0]),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rdlm_dp #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_sample  (in_tdata),
    .in_last    (in_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_level  (out_tdata)
  );

endmodule

FILE: sv/rdlm_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdlm_chk
// port-level checks of the level meter, bound to the top level
// ----------------------------------------------------------------------------
module rdlm_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [0:0]  in_tuser,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a waiting level holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat dropped or changed while stalled");

  // a clear beat always leaves the unit busy for its decision cycle
  a_clr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] |=> !in_tready)
    else $error("clear beat did not occupy the unit");

  // a block end starts the divide, so the unit is busy afterwards
  a_blk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser[0] && in_tlast |=> !in_tready)
    else $error("block end did not start the level computation");

  // a new level only appears out of a busy cycle
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("level emitted without a computation");

endmodule

bind rms_db_level_meter_unit rdlm_chk u_rdlm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the rms decibel level meter unit
// ----------------------------------------------------------------------------
// Drives sample and clear beats on the input stream, predicts each emitted
// level with a bit-exact fixed-point model of the square-sum, log2 table and
// squared dB curve, and checks every level beat in order. A short table of
// directed beats covers full scale, silence, quiet blocks, clears and
// discarded partial blocks. One block runs to the length cap without tlast.
// Random phases then sweep the change threshold from 0 to 65535 with mostly
// well-formed blocks, some broken blocks and lone clears, while both stream
// sides idle at random.
module tb;

  localparam int unsigned MAX_BLOCK   = 4096;
  localparam int unsigned PHASE_BEATS = 230;   // random beats per threshold phase
  localparam int unsigned SETTLE      = 120;   // covers the longest block-end latency
  localparam int unsigned DRAIN_LIMIT = 20000;

  // request kinds carried on tuser
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // how a directed row is checked
  localparam logic CHK_PRED  = 1'b0;
  localparam logic CHK_FIXED = 1'b1;

  localparam logic [15:0] LEVEL_FULL  = 16'hFFFF;
  localparam logic [15:0] THR_AT_RST  = 16'd328;
  localparam int unsigned QUIET_LIMIT = 10;
  localparam int unsigned DB_SLOPE    = 3288;  // 65536 * 10*log10(2) / 60

  // round(65536 * log2(1 + i/16))
  localparam int unsigned LOG2_SEG [17] = '{
    0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
    42196, 45904, 49472, 52911, 56228, 59434, 62534, 65536
  };

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_t;

  typedef struct packed {
    logic        req;
    logic [15:0] smp;
    logic        last;
    logic        chk;
    logic        want_emit;
    logic [15:0] want_level;
  } beat_row_t;

  // directed beats; fixed rows carry the level that follows at a glance
  localparam int unsigned N_ROWS = 21;
  localparam beat_row_t DIRECTED_ROWS [N_ROWS] = '{
    // silent block, level stays at zero
    '{REQ_SAMPLE, 16'h0000, 1'b1, CHK_FIXED, 1'b0, 16'h0000},
    // most negative sample squares to exactly full scale
    '{REQ_SAMPLE, 16'h8000, 1'b1, CHK_FIXED, 1'b1, LEVEL_FULL},
    // most positive sample, a hair below full scale
    '{REQ_SAMPLE, 16'h7FFF, 1'b1, CHK_PRED,  1'b0, 16'h0000},
    // clear with a nonzero held level emits zero
    '{REQ_CLEAR,  16'h0000, 1'b0, CHK_FIXED, 1'b1, 16'h0000},
    // clear with level already zero, other fields ignored
    '{REQ_CLEAR,  16'hFFFF, 1'b1, CHK_FIXED, 1'b0, 16'h0000},
    // quiet block, mean square 9
    '{REQ_SAMPLE, 16'h0003, 1'b1, CHK_FIXED, 1'b0, 16'h0000},
    // mean square 11, just above the quiet limit
    '{REQ_SAMPLE, 16'h0004, 1'b0, CHK_PRED,  1'b0, 16'h0000},
    '{REQ_SAMPLE, 16'h0004, 1'b0, CHK_PRED,  1'b0, 16'h0000},
    '{REQ_SAMPLE, 16'h0001, 1'b1, CHK_PRED,  1'b0, 16'h0000},
    // mid-level block with mixed signs
    '{REQ_SAMPLE, 16'h03E8, 1'b0, CHK_PRED,  1'b0, 16'h0000},
    '{REQ_SAMPLE, 16'hFC18, 1'b0, CHK_PRED,  1'b0, 16'h0000},
    '{REQ_SAMPLE, 16'h01F4, 1'b1, CHK_PRED,  1'b0, 16'h0000},
    // partial block thrown away by a clear
    '{REQ_SAMPLE, 16'h4E20, 1'b0, CHK_PRED,  1'b0, 16'h0000},
    '{REQ_CLEAR,  16'h0000, 1'b0, CHK_PRED,  1'b0, 16'h0000},
    '{REQ_SAMPLE, 16'h0000, 1'b1, CHK_PRED,  1'b0, 16'h0000},
    // jump from zero to near full scale
    '{REQ_SAMPLE, 16'h7FFF, 1'b1, CHK_PRED,  1'b0, 16'h0000},
    // mean square 1 drops the level to zero
    '{REQ_SAMPLE, 16'hFFFF, 1'b1, CHK_FIXED, 1'b1, 16'h0000},
    '{REQ_SAMPLE, 16'h5A5A, 1'b0, CHK_PRED,  1'b0, 16'h0000},
    '{REQ_SAMPLE, 16'hA5A5, 1'b1, CHK_PRED,  1'b0, 16'h0000},
    // mean square 2^16, inside the dB range
    '{REQ_SAMPLE, 16'h0100, 1'b1, CHK_PRED,  1'b0, 16'h0000},
    '{REQ_CLEAR,  16'h0000, 1'b0, CHK_PRED,  1'b0, 16'h0000}
  };

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;    // [15:0] sample (signed)
  logic [0:0]  in_tuser   = '0;    // [0] req_type
  logic        in_tlast   = 1'b0;  // last_in_block
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [15:0] level, q0.16
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data   = '0;    // change_threshold

  // predictor state, mirrors the unit after each accepted beat
  logic [63:0] sq_acc;
  int unsigned sq_count;
  logic [15:0] held_lvl;
  logic [15:0] chg_thr;

  logic [15:0] pending_levels [$];

  int unsigned failures     = 0;
  int unsigned beats_sent   = 0;
  int unsigned block_ends   = 0;
  int unsigned clears_sent  = 0;
  int unsigned levels_seen  = 0;
  int unsigned thr_settings = 1;
  int unsigned burst_left   = 0;

  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned rx_tick = 0;

  rms_db_level_meter_unit #(
    .MAX_BLOCK (MAX_BLOCK)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #20_000_000;
    $display("timeout with %0d levels still pending", pending_levels.size());
    $display("Test completed with failures");
    $finish;
  end

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
    failures++;
  endtask

  // mean square to display level: log2 by msb search and table
  // interpolation, distance to full scale scaled to dB/60, then squared
  function automatic logic [15:0] mean_to_display(input logic [63:0] mean);
    int unsigned msb;
    int unsigned seg;
    logic [63:0] mant;
    logic [63:0] rem;
    logic [63:0] frac;
    logic [63:0] log_dist;
    logic [63:0] scaled;
    logic [63:0] norm;
    logic [63:0] sq;
    if (mean <= 64'(QUIET_LIMIT)) return 16'h0000;
    if (mean >= (64'd1 << 30)) return LEVEL_FULL;
    msb = 0;
    while (msb < 30 && (mean >> (msb + 1)) != 64'd0) msb++;
    mant     = mean << (30 - msb);
    seg      = int'(mant[29:26]);
    rem      = 64'(mant[25:10]);
    frac     = 64'(LOG2_SEG[seg]) +
               ((64'(LOG2_SEG[seg + 1] - LOG2_SEG[seg]) * rem) >> 16);
    log_dist = 64'(30 * 65536) - (64'(msb) * 64'd65536 + frac);
    scaled   = (log_dist * 64'(DB_SLOPE) + 64'd32768) >> 16;
    norm     = (scaled >= 64'd65536) ? 64'd0 : 64'd65536 - scaled;
    sq       = (norm * norm + 64'd32768) >> 16;
    return (sq > 64'hFFFF) ? LEVEL_FULL : sq[15:0];
  endfunction

  // advance the predictor by one accepted beat
  task automatic meter_step(input logic req, input logic [15:0] smp, input logic last,
                            output logic emit, output logic [15:0] lvl);
    int          sval;
    logic [63:0] mag;
    logic [63:0] mean;
    logic [15:0] next_lvl;
    logic [15:0] delta;
    emit = 1'b0;
    lvl  = 16'h0000;
    if (req == REQ_CLEAR) begin
      sq_acc   = '0;
      sq_count = 0;
      clears_sent++;
      if (held_lvl != 16'h0000) begin
        held_lvl = 16'h0000;
        emit     = 1'b1;
      end
      return;
    end
    sval = $signed(smp);
    mag  = 64'((sval < 0) ? -sval : sval);
    sq_acc += mag * mag;
    sq_count++;
    // block ends on tlast or on reaching the length cap
    if (!last && sq_count < MAX_BLOCK) return;
    mean     = sq_acc / 64'(sq_count);
    sq_acc   = '0;
    sq_count = 0;
    block_ends++;
    next_lvl = mean_to_display(mean);
    delta    = (next_lvl > held_lvl) ? next_lvl - held_lvl : held_lvl - next_lvl;
    if (delta > chg_thr) begin
      held_lvl = next_lvl;
      emit     = 1'b1;
      lvl      = next_lvl;
    end
  endtask

  // sender pacing: bursts of back-to-back beats, then a random gap
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left = $urandom_range(1, 40);
  endtask

  // one input beat; the expected level is queued when the beat is taken
  task automatic send_beat(input logic req, input logic [15:0] smp, input logic last,
                           output logic emit, output logic [15:0] lvl);
    in_tvalid   <= 1'b1;
    in_tuser[0] <= req;
    in_tdata    <= smp;
    in_tlast    <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
    meter_step(req, smp, last, emit, lvl);
    if (emit) pending_levels.push_back(lvl);
    pace_sender();
  endtask

  // stop sending and wait until every predicted level has come out,
  // then let a block end with no emission finish its pass
  task automatic drain();
    int unsigned waited;
    in_tvalid <= 1'b0;
    waited = 0;
    while (pending_levels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    while (pending_levels.size() != 0) report("level never emitted", 16'h0000,
                                              pending_levels.pop_front());
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] thr);
    cfg_valid <= 1'b1;
    cfg_data  <= thr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    chg_thr = thr;
    thr_settings++;
  endtask

  // a block of random samples at a random amplitude; a broken block
  // never sees tlast and is thrown away by a clear
  task automatic send_block(input int unsigned len, input bit broken);
    int unsigned        shift;
    logic signed [15:0] raw;
    logic               emit;
    logic [15:0]        lvl;
    shift = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    for (int unsigned i = 0; i < len; i++) begin
      raw = $urandom;
      send_beat(REQ_SAMPLE, raw >>> shift, (i == len - 1) && !broken, emit, lvl);
    end
    if (broken) send_beat(REQ_CLEAR, 16'($urandom), 1'($urandom), emit, lvl);
  endtask

  // level checker and receiver stall pattern
  always @(posedge clk) begin
    logic [15:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      levels_seen++;
      if (pending_levels.size() == 0) begin
        report("level beat with nothing pending", out_tdata, 16'h0000);
      end else begin
        want = pending_levels.pop_front();
        if (out_tdata !== want) report("level mismatch", out_tdata, want);
      end
    end
    rx_tick++;
    if (rx_tick % 64 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
      default:   out_tready <= 1'((rx_tick >> 2) & 1);
    endcase
  end

  initial begin
    logic [15:0] thr_plan [5];
    logic        emit;
    logic [15:0] lvl;
    int unsigned pick;
    int unsigned len;
    int unsigned phase_start;

    // predictor starts at the reset state
    sq_acc   = '0;
    sq_count = 0;
    held_lvl = 16'h0000;
    chg_thr  = THR_AT_RST;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table at the reset threshold
    for (int unsigned r = 0; r < N_ROWS; r++) begin
      send_beat(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].smp, DIRECTED_ROWS[r].last,
                emit, lvl);
      if (DIRECTED_ROWS[r].chk == CHK_FIXED &&
          (emit != DIRECTED_ROWS[r].want_emit ||
           (emit && lvl != DIRECTED_ROWS[r].want_level)))
        report("directed row disagrees with predictor", lvl, DIRECTED_ROWS[r].want_level);
    end

    // block with no tlast, closed by the length cap
    for (int unsigned i = 0; i < MAX_BLOCK; i++)
      send_beat(REQ_SAMPLE, 16'($urandom), 1'b0, emit, lvl);
    send_beat(REQ_SAMPLE, 16'h0002, 1'b1, emit, lvl);
    drain();

    // threshold sweep: zero, never-emit, one, random, back to reset value
    thr_plan[0] = 16'h0000;
    thr_plan[1] = 16'hFFFF;
    thr_plan[2] = 16'h0001;
    thr_plan[3] = 16'($urandom_range(0, 4095));
    thr_plan[4] = THR_AT_RST;

    for (int unsigned p = 0; p < 5; p++) begin
      write_threshold(thr_plan[p]);
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          send_beat(REQ_CLEAR, 16'($urandom), 1'($urandom), emit, lvl);
        end else if (pick < 10) begin
          send_block($urandom_range(1, 8), 1'b1);
        end else if (pick < 12) begin
          // let the unit run dry before going on
          drain();
        end else begin
          len = $urandom_range(0, 99);
          if (len < 85)      len = $urandom_range(1, 16);
          else if (len < 97) len = $urandom_range(17, 64);
          else               len = $urandom_range(65, 200);
          send_block(len, 1'b0);
        end
      end
      drain();
    end

    $display("sent %0d beats: %0d block ends, %0d clears, one capped block", beats_sent,
             block_ends, clears_sent);
    $display("checked %0d level beats across %0d threshold settings", levels_seen,
             thr_settings);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
